// ----- src/rmod_pkg.sv -----
// Shared types and constants of the region-of-interest motion onset detector.
// Depends on nothing; every other file imports it.
package rmod_pkg;

	localparam int MAX_DIM = 1024;

	localparam int PIX_W     = 8;
	localparam int COORD_W   = 10;
	localparam int DIM_W     = 11;
	localparam int THR_W     = 8;
	localparam int SUM_W     = 28;
	localparam int AREA_W    = 2 * DIM_W;
	localparam int BOUND_W   = THR_W + AREA_W;
	localparam int RUN_W     = 2;
	localparam int EDGE_W    = DIM_W + 1;
	localparam int LIMIT_W   = $clog2(MAX_DIM) + 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [LIMIT_W-1:0] DIM_LIMIT = LIMIT_W'(MAX_DIM);
	localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_W    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_H    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_THR = 3'd5;

	localparam logic [COORD_W-1:0] RST_ROI_X    = 10'd80;
	localparam logic [COORD_W-1:0] RST_ROI_Y    = 10'd70;
	localparam logic [DIM_W-1:0]   RST_ROI_W    = 11'd60;
	localparam logic [DIM_W-1:0]   RST_ROI_H    = 11'd40;
	localparam logic [THR_W-1:0]   RST_DIFF_THR = 8'd25;
	localparam logic [THR_W-1:0]   RST_MEAN_THR = 8'd10;
	localparam logic [AREA_W-1:0]  RST_AREA     = AREA_W'(60 * 40);
	localparam logic [BOUND_W-1:0] RST_BOUND    = BOUND_W'(10 * 60 * 40);

	localparam logic [RUN_W-1:0] RUN_ONSET = 2'd1;
	localparam logic [RUN_W-1:0] RUN_MAX   = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0]   now_pixel;
		logic [PIX_W-1:0]   prev_pixel;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_last;
	} pix_t;

	typedef struct packed {
		logic             detected;
		logic             roi_active;
		logic [SUM_W-1:0] roi_sum;
	} res_t;

	typedef struct packed {
		logic [COORD_W-1:0] roi_x;
		logic [COORD_W-1:0] roi_y;
		logic [DIM_W-1:0]   roi_w;
		logic [DIM_W-1:0]   roi_h;
		logic [THR_W-1:0]   diff_thr;
		logic [THR_W-1:0]   mean_thr;
	} cfg_t;

	// kept difference of one pixel, already gated by region membership
	typedef struct packed {
		logic [PIX_W-1:0] diff;
		logic             last;
	} acc_t;

endpackage

// ----- src/rmod_cfg_regs.sv -----
// Configuration registers and the registered activity bound mean_thr * w * h.
// Depends on rmod_pkg.
module rmod_cfg_regs
	import rmod_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic [BOUND_W-1:0]    bound
);

	cfg_t               cfg_q;
	logic [AREA_W-1:0]  area_q;
	logic [BOUND_W-1:0] bound_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_x    <= RST_ROI_X;
			cfg_q.roi_y    <= RST_ROI_Y;
			cfg_q.roi_w    <= RST_ROI_W;
			cfg_q.roi_h    <= RST_ROI_H;
			cfg_q.diff_thr <= RST_DIFF_THR;
			cfg_q.mean_thr <= RST_MEAN_THR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROI_X:    cfg_q.roi_x    <= cfg_data[COORD_W-1:0];
				CFG_ROI_Y:    cfg_q.roi_y    <= cfg_data[COORD_W-1:0];
				CFG_ROI_W:    cfg_q.roi_w    <= cfg_data[DIM_W-1:0];
				CFG_ROI_H:    cfg_q.roi_h    <= cfg_data[DIM_W-1:0];
				CFG_DIFF_THR: cfg_q.diff_thr <= cfg_data[THR_W-1:0];
				CFG_MEAN_THR: cfg_q.mean_thr <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// two multiplies, one register each; a roi_w or roi_h write reaches bound via area_q, then bound_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q  <= RST_AREA;
			bound_q <= RST_BOUND;
		end else begin
			area_q  <= AREA_W'(cfg_q.roi_w) * AREA_W'(cfg_q.roi_h);
			bound_q <= BOUND_W'(cfg_q.mean_thr) * BOUND_W'(area_q);
		end
	end

	assign cfg   = cfg_q;
	assign bound = bound_q;

endmodule

// ----- src/rmod_pixel_stage.sv -----
// Input register and per-pixel work: absolute difference, threshold-to-zero,
// region membership. Feeds the accumulator through the second stage register.
// Depends on rmod_pkg.
module rmod_pixel_stage
	import rmod_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  pix_t pix,
	input  cfg_t cfg,
	input  logic take,
	output logic vld_s2,
	output acc_t acc_s2
);

	logic               vld_s1;
	pix_t               pix_s1;
	logic               s1_free;
	logic               s2_free;
	logic [PIX_W-1:0]   diff_raw;
	logic [EDGE_W-1:0]  col_end;
	logic [EDGE_W-1:0]  row_end;
	logic               in_img;
	logic               in_roi;
	acc_t               acc_d;

	assign s2_free   = !vld_s2 || take;
	assign s1_free   = !vld_s1 || s2_free;
	assign pix_stall = !s1_free;

	always_comb begin
		diff_raw = (pix_s1.now_pixel > pix_s1.prev_pixel) ?
			(pix_s1.now_pixel - pix_s1.prev_pixel) :
			(pix_s1.prev_pixel - pix_s1.now_pixel);
		col_end  = EDGE_W'(cfg.roi_x) + EDGE_W'(cfg.roi_w);
		row_end  = EDGE_W'(cfg.roi_y) + EDGE_W'(cfg.roi_h);
		in_img   = (LIMIT_W'(pix_s1.col) < DIM_LIMIT) && (LIMIT_W'(pix_s1.row) < DIM_LIMIT);
		in_roi   = (pix_s1.col >= cfg.roi_x) && (EDGE_W'(pix_s1.col) < col_end) &&
			(pix_s1.row >= cfg.roi_y) && (EDGE_W'(pix_s1.row) < row_end);
		acc_d.diff = (diff_raw > cfg.diff_thr && in_img && in_roi) ? diff_raw : '0;
		acc_d.last = pix_s1.frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				vld_s1 <= pix_valid;
			end
			if (s2_free) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && s1_free) begin
			pix_s1 <= pix;
		end
		if (vld_s1 && s2_free) begin
			acc_s2 <= acc_d;
		end
	end

`ifndef SYNTHESIS
	// a frame-end item waiting on the result register must not be dropped or changed
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !take) |=> (vld_s2 && $stable(acc_s2)))
		else $error("second stage item lost while held");
`endif

endmodule

// ----- src/rmod_frame_acc.sv -----
// Frame accumulator: saturating region sum, activity compare at frame end,
// onset run counter and the result register. Depends on rmod_pkg.
module rmod_frame_acc
	import rmod_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s2,
	input  acc_t               acc_s2,
	input  logic [BOUND_W-1:0] bound,
	output logic               take,
	output logic               res_valid,
	input  logic               res_stall,
	output res_t               res
);

	logic [SUM_W-1:0] sum_q;
	logic [RUN_W-1:0] run_q;
	logic             res_valid_q;
	res_t             res_q;
	logic             res_free;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_new;
	logic             active;
	logic [RUN_W-1:0] run_nxt;

	assign res_free = !res_valid_q || !res_stall;
	// items without frame end never need the result register
	assign take     = vld_s2 && (!acc_s2.last || res_free);

	always_comb begin
		sum_add = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(acc_s2.diff);
		sum_new = (sum_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
		active  = BOUND_W'(sum_new) >= bound;
		if (!active) begin
			run_nxt = '0;
		end else if (run_q == RUN_MAX) begin
			run_nxt = RUN_MAX;
		end else begin
			run_nxt = run_q + RUN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			run_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				sum_q <= acc_s2.last ? '0 : sum_new;
				if (acc_s2.last) begin
					run_q <= run_nxt;
				end
			end
			if (res_free) begin
				res_valid_q <= take && acc_s2.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && acc_s2.last) begin
			res_q.detected   <= (run_nxt == RUN_ONSET);
			res_q.roi_active <= active;
			res_q.roi_sum    <= sum_new;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_onset_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.detected || res.roi_active))
		else $error("onset reported on inactive frame");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && acc_s2.last) |=> (sum_q == '0 && res_valid))
		else $error("frame end did not clear sum or load result");

	a_onset_run: assert property (@(posedge clk) disable iff (!arst_n)
		(take && acc_s2.last) |=> (res.detected == (run_q == RUN_ONSET)))
		else $error("onset flag disagrees with run counter");
`endif

endmodule

// ----- src/roi_motion_onset_detector.sv -----
// Top level of the region-of-interest motion onset detector.
// Depends on rmod_pkg, rmod_cfg_regs, rmod_pixel_stage, rmod_frame_acc.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------
//   pix     | pix_valid / pix_stall | pix_t: pixel pair, col, row, frame end
//   res     | res_valid / res_stall | res_t: detected, roi_active, roi_sum
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (ready always high)
//
// One pixel item per cycle while pix_stall is low; a frame-end item yields its
// result through the input register at the accepting edge, then the difference
// register and the result register.
// Reset clears the sum, the run counter and all valid flags, and loads the
// register defaults. A stalled result blocks only once a frame-end item reaches
// the second stage; pixels in between keep flowing. The bound register follows
// a configuration write through the registered area product.
module roi_motion_onset_detector
	import rmod_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_t                  pix,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t               cfg;
	logic [BOUND_W-1:0] bound;
	logic               take;
	logic               vld_s2;
	acc_t               acc_s2;

	rmod_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.bound     (bound)
	);

	rmod_pixel_stage u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg       (cfg),
		.take      (take),
		.vld_s2    (vld_s2),
		.acc_s2    (acc_s2)
	);

	rmod_frame_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s2    (vld_s2),
		.acc_s2    (acc_s2),
		.bound     (bound),
		.take      (take),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
